[src/bce_pkg.sv]
package bce_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int NUM_PTS    = 4;
  localparam int IDX_W      = 2;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_STAGES = 5;

  localparam logic [REG_IDX_W-1:0] REG_CTRL0_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CTRL0_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CTRL3_X = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CTRL3_Y = 3'd7;

  localparam logic CMD_EVAL = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

[src/bce_if.sv]
interface bce_in_if #(
  parameter int CW = bce_pkg::COORD_WIDTH_DEF,
  parameter int TW = bce_pkg::T_FRAC_BITS_DEF + 1
) ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [TW-1:0]        param_t;
  logic signed [CW-1:0] query_x;
  logic signed [CW-1:0] query_y;
  logic [CW-1:0]        pick_radius;

  modport source (
    output valid, command, param_t, query_x, query_y, pick_radius,
    input  ready
  );
  modport sink (
    input  valid, command, param_t, query_x, query_y, pick_radius,
    output ready
  );
endinterface

interface bce_out_if #(
  parameter int CW = bce_pkg::COORD_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [CW-1:0]           curve_x;
  logic signed [CW-1:0]           curve_y;
  logic [bce_pkg::IDX_W-1:0]      nearest_index;
  logic                           found;

  modport source (
    output valid, curve_x, curve_y, nearest_index, found,
    input  ready
  );
  modport sink (
    input  valid, curve_x, curve_y, nearest_index, found,
    output ready
  );
endinterface

[src/bce_eval.sv]
module bce_eval #(
  parameter int CW = bce_pkg::COORD_WIDTH_DEF,
  parameter int F  = bce_pkg::T_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  bce_pkg::stage_en_t    en,
  input  logic [F:0]            param_t,
  input  logic signed [CW-1:0]  ctrl_x [bce_pkg::NUM_PTS],
  input  logic signed [CW-1:0]  ctrl_y [bce_pkg::NUM_PTS],
  output logic signed [CW-1:0]  curve_x,
  output logic signed [CW-1:0]  curve_y
);
  import bce_pkg::*;

  localparam int TW = F + 1;           // t, u, a, b, c
  localparam int QW = 2 * TW;          // first products
  localparam int PW = 2 * TW + 2;      // weight products
  localparam int WW = F + 3;           // weights, up to 3 * 2^F
  localparam int MW = WW + 1 + CW;     // weight times coordinate
  localparam int SW = MW + 2;          // sum of four
  localparam int RW = SW - F;          // after the final shift

  localparam logic [TW-1:0] T_ONE  = {1'b1, {F{1'b0}}};
  localparam logic [QW-1:0] HALF_Q = {{(QW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [PW-1:0] HALF_P = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF_S = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  // stage 1: clamp t, form u, first products
  logic [TW-1:0] t_cl, u_cl;
  logic [TW-1:0] s1_t, s1_u;
  logic [QW-1:0] s1_uu, s1_ut, s1_tt;

  assign t_cl = (param_t > T_ONE) ? T_ONE : param_t;
  assign u_cl = T_ONE - t_cl;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_t  <= t_cl;
      s1_u  <= u_cl;
      s1_uu <= QW'(u_cl) * QW'(u_cl);
      s1_ut <= QW'(u_cl) * QW'(t_cl);
      s1_tt <= QW'(t_cl) * QW'(t_cl);
    end
  end

  // stage 2: round a, b, c and form weight products
  logic [QW-1:0]   a_sum, b_sum, c_sum;
  logic [TW-1:0]   a_r, b_r, c_r;
  logic [TW+1:0]   a3, b3;
  logic [PW-1:0]   s2_p [NUM_PTS];

  assign a_sum = s1_uu + HALF_Q;
  assign b_sum = s1_ut + HALF_Q;
  assign c_sum = s1_tt + HALF_Q;
  assign a_r   = a_sum[F+TW-1:F];
  assign b_r   = b_sum[F+TW-1:F];
  assign c_r   = c_sum[F+TW-1:F];
  assign a3    = {a_r, 1'b0} + (TW+2)'(a_r);
  assign b3    = {b_r, 1'b0} + (TW+2)'(b_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_p[0] <= PW'(a_r) * PW'(s1_u);
      s2_p[1] <= PW'(a3) * PW'(s1_t);
      s2_p[2] <= PW'(b3) * PW'(s1_t);
      s2_p[3] <= PW'(c_r) * PW'(s1_t);
    end
  end

  // stage 3: round weights, multiply by control points
  logic [PW-1:0]        w_sum [NUM_PTS];
  logic signed [MW-1:0] w_ext [NUM_PTS];
  logic signed [MW-1:0] cx_ext [NUM_PTS];
  logic signed [MW-1:0] cy_ext [NUM_PTS];
  logic signed [MW-1:0] s3_mx [NUM_PTS];
  logic signed [MW-1:0] s3_my [NUM_PTS];

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      w_sum[i]  = s2_p[i] + HALF_P;
      w_ext[i]  = MW'({1'b0, w_sum[i][F+WW-1:F]});
      cx_ext[i] = MW'(ctrl_x[i]);
      cy_ext[i] = MW'(ctrl_y[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        s3_mx[i] <= w_ext[i] * cx_ext[i];
        s3_my[i] <= w_ext[i] * cy_ext[i];
      end
    end
  end

  // stage 4: sum of the four terms
  logic signed [SW-1:0] s4_sx, s4_sy;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_sx <= SW'(s3_mx[0]) + SW'(s3_mx[1]) + SW'(s3_mx[2]) + SW'(s3_mx[3]);
      s4_sy <= SW'(s3_my[0]) + SW'(s3_my[1]) + SW'(s3_my[2]) + SW'(s3_my[3]);
    end
  end

  // stage 5: round half up, floor shift, saturate
  logic signed [SW-1:0] rx, ry;
  logic signed [RW-1:0] qx, qy;
  logic signed [CW-1:0] satx, saty;

  assign rx = s4_sx + HALF_S;
  assign ry = s4_sy + HALF_S;
  assign qx = rx[SW-1:F];
  assign qy = ry[SW-1:F];

  always_comb begin
    if ((&qx[RW-1:CW-1]) || !(|qx[RW-1:CW-1])) begin
      satx = qx[CW-1:0];
    end else begin
      satx = qx[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    if ((&qy[RW-1:CW-1]) || !(|qy[RW-1:CW-1])) begin
      saty = qy[CW-1:0];
    end else begin
      saty = qy[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      curve_x <= satx;
      curve_y <= saty;
    end
  end

endmodule

[src/bce_pick.sv]
module bce_pick #(
  parameter int CW = bce_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  bce_pkg::stage_en_t          en,
  input  logic signed [CW-1:0]        query_x,
  input  logic signed [CW-1:0]        query_y,
  input  logic [CW-1:0]               pick_radius,
  input  logic signed [CW-1:0]        ctrl_x [bce_pkg::NUM_PTS],
  input  logic signed [CW-1:0]        ctrl_y [bce_pkg::NUM_PTS],
  output logic [bce_pkg::IDX_W-1:0]   nearest_index,
  output logic                        found
);
  import bce_pkg::*;

  localparam int SQW = 2 * CW;
  localparam int DW  = 2 * CW + 1;

  // stage 1: absolute differences
  logic signed [CW:0] ddx [NUM_PTS];
  logic signed [CW:0] ddy [NUM_PTS];
  logic signed [CW:0] adx [NUM_PTS];
  logic signed [CW:0] ady [NUM_PTS];
  logic [CW-1:0]      s1_dx [NUM_PTS];
  logic [CW-1:0]      s1_dy [NUM_PTS];
  logic [CW-1:0]      s1_rad;

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      ddx[i] = {query_x[CW-1], query_x} - {ctrl_x[i][CW-1], ctrl_x[i]};
      ddy[i] = {query_y[CW-1], query_y} - {ctrl_y[i][CW-1], ctrl_y[i]};
      adx[i] = ddx[i][CW] ? -ddx[i] : ddx[i];
      ady[i] = ddy[i][CW] ? -ddy[i] : ddy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        s1_dx[i] <= adx[i][CW-1:0];
        s1_dy[i] <= ady[i][CW-1:0];
      end
      s1_rad <= pick_radius;
    end
  end

  // stage 2: squares
  logic [SQW-1:0] s2_sx [NUM_PTS];
  logic [SQW-1:0] s2_sy [NUM_PTS];
  logic [SQW-1:0] s2_rsq;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        s2_sx[i] <= SQW'(s1_dx[i]) * SQW'(s1_dx[i]);
        s2_sy[i] <= SQW'(s1_dy[i]) * SQW'(s1_dy[i]);
      end
      s2_rsq <= SQW'(s1_rad) * SQW'(s1_rad);
    end
  end

  // stage 3: squared distances, exact
  logic [DW-1:0] s3_d [NUM_PTS];
  logic [DW-1:0] s3_rsq;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        s3_d[i] <= DW'(s2_sx[i]) + DW'(s2_sy[i]);
      end
      s3_rsq <= DW'(s2_rsq);
    end
  end

  // stage 4: pairwise minimum, radius test per point
  logic [NUM_PTS-1:0] s4_in;
  logic [DW-1:0]      s4_d01, s4_d23;
  logic               s4_i01, s4_i23;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        s4_in[i] <= (s3_d[i] <= s3_rsq);
      end
      // strict compare keeps the lower index on a tie
      if (s3_d[1] < s3_d[0]) begin
        s4_d01 <= s3_d[1];
        s4_i01 <= 1'b1;
      end else begin
        s4_d01 <= s3_d[0];
        s4_i01 <= 1'b0;
      end
      if (s3_d[3] < s3_d[2]) begin
        s4_d23 <= s3_d[3];
        s4_i23 <= 1'b1;
      end else begin
        s4_d23 <= s3_d[2];
        s4_i23 <= 1'b0;
      end
    end
  end

  // stage 5: final pick
  logic [IDX_W-1:0] best;

  assign best = (s4_d23 < s4_d01) ? {1'b1, s4_i23} : {1'b0, s4_i01};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      nearest_index <= best;
      found         <= s4_in[best];
    end
  end

endmodule

[src/cubic_bezier_eval_and_pick_unit.sv]
// Channel   Dir  Handshake     Payload
// request   in   valid/ready   command, param_t, query_x, query_y, pick_radius
// response  out  valid/ready   curve_x, curve_y, nearest_index, found
// cfg       in   cfg_wr_en     cfg_index, cfg_data (control points 0..3, x then y)
//
// Five register stages; one transfer per cycle in steady state while response.ready stays high.
// Stage depth is set by one multiplier per stage (t products, weights, weight times
// point) and the four-term sum. Reset clears the valid bits and the control points.
// Each stage holds while the one after it is full and stalled, so a stall on the
// response side fills the bubbles first and then drops request.ready.
module cubic_bezier_eval_and_pick_unit #(
  parameter int COORD_WIDTH = bce_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bce_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bce_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  bce_in_if.sink                        request,
  bce_out_if.source                     response
);
  import bce_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  // control point registers
  logic signed [COORD_WIDTH-1:0] ctrl_x [NUM_PTS];
  logic signed [COORD_WIDTH-1:0] ctrl_y [NUM_PTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        ctrl_x[i] <= '0;
        ctrl_y[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CTRL0_X: ctrl_x[0] <= cfg_data;
        REG_CTRL0_Y: ctrl_y[0] <= cfg_data;
        REG_CTRL1_X: ctrl_x[1] <= cfg_data;
        REG_CTRL1_Y: ctrl_y[1] <= cfg_data;
        REG_CTRL2_X: ctrl_x[2] <= cfg_data;
        REG_CTRL2_Y: ctrl_y[2] <= cfg_data;
        REG_CTRL3_X: ctrl_x[3] <= cfg_data;
        REG_CTRL3_Y: ctrl_y[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  stage_en_t vld;
  stage_en_t adv;
  stage_en_t cmd;

  always_comb begin
    adv[LAST] = !vld[LAST] || response.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= request.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cmd[0] <= request.command;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        cmd[k] <= cmd[k-1];
      end
    end
  end

  assign request.ready = adv[0];

  // datapaths
  logic signed [COORD_WIDTH-1:0] ev_x, ev_y;
  logic [IDX_W-1:0]              pk_idx;
  logic                          pk_found;

  bce_eval #(
    .CW (COORD_WIDTH),
    .F  (T_FRAC_BITS)
  ) u_eval (
    .clk     (clk),
    .en      (adv),
    .param_t (request.param_t),
    .ctrl_x  (ctrl_x),
    .ctrl_y  (ctrl_y),
    .curve_x (ev_x),
    .curve_y (ev_y)
  );

  bce_pick #(
    .CW (COORD_WIDTH)
  ) u_pick (
    .clk           (clk),
    .en            (adv),
    .query_x       (request.query_x),
    .query_y       (request.query_y),
    .pick_radius   (request.pick_radius),
    .ctrl_x        (ctrl_x),
    .ctrl_y        (ctrl_y),
    .nearest_index (pk_idx),
    .found         (pk_found)
  );

  assign response.valid         = vld[LAST];
  assign response.curve_x       = (cmd[LAST] == CMD_EVAL) ? ev_x : '0;
  assign response.curve_y       = (cmd[LAST] == CMD_EVAL) ? ev_y : '0;
  assign response.nearest_index = (cmd[LAST] == CMD_PICK) ? pk_idx : '0;
  assign response.found         = (cmd[LAST] == CMD_PICK) ? pk_found : 1'b0;

endmodule
